// ===== design/s256h_pkg.sv =====
// Shared types, constants and functions for the SHA-256 byte-stream hasher.
// Holds the round constant table, initial hash values and the sigma helpers.
`timescale 1ns / 1ps

package s256h_pkg;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL      = 6'd56;
    localparam logic [5:0] LAST_FILL     = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       shift_en;
        logic [7:0] data;
        logic       start;
        logic       restart;
        logic [2:0] sel;
    } t_core_ctl;

    typedef struct packed {
        logic done;
    } t_core_sts;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
        rotr = (x >> r) | (x << (32 - r));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        init_hash = h;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        round_k = k;
    endfunction

endpackage

// ===== design/s256h_core.sv =====
// Compression core: 512-bit block/schedule shift line, one round per cycle.
// Depends on s256h_pkg for round constants, initial hash values and sigmas.
`timescale 1ns / 1ps

module s256h_core
    import s256h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_ctl   i_ctl,
    output t_core_sts   o_sts,
    output logic [31:0] o_word
);

    logic [511:0] r_blk;
    logic [31:0]  r_v [8];
    logic [31:0]  n_v [8];
    logic [31:0]  r_h [8];
    logic [5:0]   r_round;
    logic         r_busy;
    logic         r_add;

    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    // W[t] sits in the top word of the shift line, W[t+15] in the bottom word
    assign w_cur = r_blk[511:480];
    assign w_new = small_sigma1(r_blk[511 - 14*32 -: 32]) + r_blk[511 - 9*32 -: 32]
                 + small_sigma0(r_blk[479:448]) + w_cur;

    assign t1 = r_v[7] + big_sigma1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + round_k(r_round) + w_cur;
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_v[0] = t1 + t2;
        n_v[1] = r_v[0];
        n_v[2] = r_v[1];
        n_v[3] = r_v[2];
        n_v[4] = r_v[3] + t1;
        n_v[5] = r_v[4];
        n_v[6] = r_v[5];
        n_v[7] = r_v[6];
    end

    // control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_add   <= 1'b0;
            r_round <= '0;
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= init_hash(3'(j));
            end
        end else begin
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_add  <= 1'b1;
                end
            end
            if (r_add) begin
                r_add <= 1'b0;
                for (int j = 0; j < 8; j++) begin
                    r_h[j] <= r_h[j] + r_v[j];
                end
            end else if (i_ctl.restart) begin
                for (int j = 0; j < 8; j++) begin
                    r_h[j] <= init_hash(3'(j));
                end
            end
        end
    end

    // payload: shift line and working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_blk <= {r_blk[503:0], i_ctl.data};
        end else if (r_busy) begin
            r_blk <= {r_blk[479:0], w_new};
        end
        if (i_ctl.start) begin
            r_v <= r_h;
        end else if (r_busy) begin
            r_v <= n_v;
        end
    end

    assign o_sts.done = r_add;
    assign o_word     = r_h[i_ctl.sel];

    a_busy_add_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_add))
        else $error("round loop and final add active together");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (!r_busy && !r_add))
        else $error("block started while compression in progress");

    a_last_round_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_round == LAST_ROUND && !i_ctl.start) |=> r_add)
        else $error("final add missing after last round");

    a_no_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.shift_en |-> !r_busy)
        else $error("byte shifted into line during rounds");

endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte-stream hasher: beat handshakes, padding
// sequencer and digest output. Depends on s256h_pkg and s256h_core.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_in_valid / o_in_stall. A beat carries i_has_byte,
//   i_data_byte and i_end_of_message. A beat without a byte and without end
//   is dropped. A beat with end closes the message after its byte, if any.
//   Output channel: o_out_valid / i_out_stall. Eight beats per message,
//   o_word_index 0..7, o_last_word high on the eighth.
// Timing
//   A byte beat that neither completes a 64-byte block nor ends the message
//   leaves the input ready for the next beat. The 64th byte starts the
//   compression: 64 rounds, one per cycle on the single round unit, then
//   the chaining add, all while o_in_stall is high. At end of message the
//   padding is shifted in one byte per cycle, pausing while a full block is
//   compressed and before the length field (up to 72 bytes over two
//   blocks) and one or two further blocks are compressed, then the digest
//   words are offered one per cycle while the receiver does not stall.
// Reset and stall
//   Reset loads the initial hash values and clears the byte and bit counts.
//   While the receiver stalls, the current digest beat is held unchanged and
//   no input beat is taken; after the last word the hash state restarts.

module sha256_byte_stream_hasher
    import s256h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_has_byte,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [2:0]  r_idx, n_idx;

    t_core_ctl   ctl;
    t_core_sts   sts;
    logic        in_take;

    s256h_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_word  (o_digest_word)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_idx       = r_idx;
        ctl         = '0;
        ctl.sel     = r_idx;
        o_out_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_has_byte) begin
                        ctl.shift_en = 1'b1;
                        ctl.data     = i_data_byte;
                        n_bits       = r_bits + BITS_PER_BYTE;
                        n_fill       = r_fill + 6'd1;
                        if (r_fill == LAST_FILL) begin
                            // block full: compress, then pad if this beat ends it
                            ctl.start = 1'b1;
                            n_state   = ST_COMP;
                            n_ret     = i_end_of_message ? ST_PAD_MARK : ST_IDLE;
                        end else if (i_end_of_message) begin
                            n_state = ST_PAD_MARK;
                        end
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD_MARK;
                    end
                end
            end
            ST_COMP: begin
                if (sts.done) begin
                    n_state = r_ret;
                end
            end
            ST_PAD_MARK: begin
                ctl.shift_en = 1'b1;
                ctl.data     = PAD_MARK_BYTE;
                n_fill       = r_fill + 6'd1;
                if (r_fill == LAST_FILL) begin
                    ctl.start = 1'b1;
                    n_state   = ST_COMP;
                    n_ret     = ST_PAD_ZERO;
                end else begin
                    n_state = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                // zero-fill up to the length field, wrapping through a block if needed
                if (r_fill == LEN_FILL) begin
                    n_state = ST_PAD_LEN;
                end else begin
                    ctl.shift_en = 1'b1;
                    ctl.data     = 8'h00;
                    n_fill       = r_fill + 6'd1;
                    if (r_fill == LAST_FILL) begin
                        ctl.start = 1'b1;
                        n_state   = ST_COMP;
                        n_ret     = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN: begin
                // bit count goes out most significant byte first
                ctl.shift_en = 1'b1;
                ctl.data     = r_bits[63:56];
                n_bits       = {r_bits[55:0], 8'h00};
                n_fill       = r_fill + 6'd1;
                if (r_fill == LAST_FILL) begin
                    ctl.start = 1'b1;
                    n_state   = ST_COMP;
                    n_ret     = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == LAST_WORD_IDX) begin
                        ctl.restart = 1'b1;
                        n_bits      = '0;
                        n_fill      = '0;
                        n_state     = ST_IDLE;
                        n_ret       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == LAST_WORD_IDX);

    a_out_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_fill == '0))
        else $error("digest offered with a partly filled block");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=> (r_state == ST_IDLE && r_bits == '0))
        else $error("hash state not restarted after last digest word");

    a_len_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD_ZERO && r_fill == LEN_FILL) |=> (r_state == ST_PAD_LEN))
        else $error("length field not started at byte 56");

endmodule
